[hw/rtl/cpg_pkg.sv]
// Shared constants, types and register codes for the circle point generator.
package cpg_pkg;

	// coordinate width of the centre registers and arc counters
	localparam int COORD_BITS = 12;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DEC_BITS   = COORD_BITS + 4;
	localparam int OUT_BITS   = COORD_BITS + 1;

	// eight mirrored points per step
	localparam int STEP_BITS = 3;
	localparam logic [STEP_BITS-1:0] LAST_POINT = '1;

	// decision variable constants of the midpoint method
	localparam logic [DEC_BITS-1:0] DEC_INIT  = DEC_BITS'(3);
	localparam logic [DEC_BITS-1:0] STEP_FLAT = DEC_BITS'(6);
	localparam logic [DEC_BITS-1:0] STEP_DIAG = DEC_BITS'(10);

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTRE_X = 2'd0,
		REG_CENTRE_Y = 2'd1,
		REG_RADIUS   = 2'd2
	} cfg_reg_t;

	// one step's arc position, handed from front to back
	typedef struct packed {
		logic [COORD_BITS-1:0] arc_x;
		logic [COORD_BITS-1:0] arc_y;
		logic                  done;
	} cpg_job_t;

endpackage

[hw/rtl/cpg_front.sv]
// Front end: accepts step requests, keeps the arc state and queues one job per emitting step.
module cpg_front import cpg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                restart,
	input  logic                queue_full,
	input  logic [RAD_BITS-1:0] radius,
	output logic                in_stall,
	output logic                push,
	output cpg_job_t            push_job
);

	logic [COORD_BITS-1:0] arc_x_q;
	logic [COORD_BITS-1:0] arc_y_q;
	logic [DEC_BITS-1:0]   decision_q;
	logic                  active_q;

	logic                  accept;
	logic                  act_eff;
	logic [COORD_BITS-1:0] x_eff;
	logic [COORD_BITS-1:0] y_eff;
	logic [DEC_BITS-1:0]   d_eff;
	logic [DEC_BITS-1:0]   r_ext;
	logic [DEC_BITS-1:0]   d_init;
	logic [DEC_BITS-1:0]   x_d;
	logic [DEC_BITS-1:0]   y_d;
	logic [DEC_BITS-1:0]   d_flat;
	logic [DEC_BITS-1:0]   d_diag;
	logic [DEC_BITS-1:0]   d_next;
	logic                  d_neg;
	logic [COORD_BITS:0]   nx;
	logic [COORD_BITS:0]   ny;
	logic                  still_active;

	function automatic logic [DEC_BITS-3:0] d_sub(input logic [DEC_BITS-1:0] a,
		input logic [DEC_BITS-1:0] b);
		logic [DEC_BITS-1:0] diff;
		diff = a - b;
		return diff[DEC_BITS-3:0];
	endfunction

	// stall while the queue has no room
	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;

	// reload the arc on restart before stepping
	assign r_ext   = {{(DEC_BITS - RAD_BITS){1'b0}}, radius};
	assign d_init  = DEC_INIT - {r_ext[DEC_BITS-2:0], 1'b0};
	assign x_eff   = restart ? '0 : arc_x_q;
	assign y_eff   = restart ? {1'b0, radius} : arc_y_q;
	assign d_eff   = restart ? d_init : decision_q;
	assign act_eff = restart || active_q;

	// decision update and next arc position
	assign x_d    = {{(DEC_BITS - COORD_BITS){1'b0}}, x_eff};
	assign y_d    = {{(DEC_BITS - COORD_BITS){1'b0}}, y_eff};
	assign d_neg  = d_eff[DEC_BITS-1];
	assign d_flat = d_eff + {x_d[DEC_BITS-3:0], 2'b00} + STEP_FLAT;
	assign d_diag = d_eff + {d_sub(x_d, y_d), 2'b00} + STEP_DIAG;
	assign d_next = d_neg ? d_flat : d_diag;

	assign nx = {1'b0, x_eff} + {{COORD_BITS{1'b0}}, 1'b1};
	assign ny = d_neg ? {1'b0, y_eff} : ({1'b0, y_eff} - {{COORD_BITS{1'b0}}, 1'b1});
	assign still_active = $signed(nx) <= $signed(ny);

	// queue a job for every step that emits points
	assign push           = accept && act_eff;
	assign push_job.arc_x = x_eff;
	assign push_job.arc_y = y_eff;
	assign push_job.done  = !still_active;

	// advance the arc state on each emitting step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_x_q    <= '0;
			arc_y_q    <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (push) begin
			arc_x_q    <= nx[COORD_BITS-1:0];
			arc_y_q    <= ny[COORD_BITS-1:0];
			decision_q <= d_next;
			active_q   <= still_active;
		end
	end

endmodule

[hw/rtl/cpg_queue.sv]
// Short job queue that decouples the front end from the point emitter.
module cpg_queue import cpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cpg_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output cpg_job_t head_job
);

	cpg_job_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full       = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = entry_q[rd_ptr_q];

	// store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full) else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("job queue underflow");

endmodule

[hw/rtl/cpg_back.sv]
// Back end: expands each queued job into eight mirrored points through an output register.
module cpg_back import cpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] centre_x,
	input  logic [COORD_BITS-1:0] centre_y,
	input  logic                  head_valid,
	input  cpg_job_t              head_job,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [OUT_BITS-1:0]   point_x,
	output logic [OUT_BITS-1:0]   point_y,
	output logic                  last_of_step,
	output logic                  circle_done
);

	cpg_job_t              job_q;
	logic                  job_valid_q;
	logic [STEP_BITS-1:0]  k_q;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   point_x_q;
	logic [OUT_BITS-1:0]   point_y_q;
	logic                  last_q;
	logic                  done_q;

	logic                  load;
	logic                  job_end;
	logic [COORD_BITS-1:0] a_sel;
	logic [COORD_BITS-1:0] b_sel;
	logic [OUT_BITS-1:0]   cx_e;
	logic [OUT_BITS-1:0]   cy_e;
	logic [OUT_BITS-1:0]   a_e;
	logic [OUT_BITS-1:0]   b_e;
	logic [OUT_BITS-1:0]   px;
	logic [OUT_BITS-1:0]   py;

	// load a point when the output register is empty or being taken
	assign load    = job_valid_q && (!out_valid_q || !out_stall);
	assign job_end = load && (k_q == LAST_POINT);
	assign pop     = head_valid && (!job_valid_q || job_end);

	// mirror the arc position: swapped octants in the upper half of the step
	assign a_sel = k_q[2] ? job_q.arc_y : job_q.arc_x;
	assign b_sel = k_q[2] ? job_q.arc_x : job_q.arc_y;
	assign cx_e  = {centre_x[COORD_BITS-1], centre_x};
	assign cy_e  = {centre_y[COORD_BITS-1], centre_y};
	assign a_e   = {1'b0, a_sel};
	assign b_e   = {1'b0, b_sel};
	assign px    = k_q[0] ? (cx_e - a_e) : (cx_e + a_e);
	assign py    = k_q[1] ? (cy_e - b_e) : (cy_e + b_e);

	// hold the current job and step through its points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
			end else if (job_end) begin
				job_valid_q <= 1'b0;
			end
			if (load) begin
				k_q <= k_q + STEP_BITS'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			point_x_q <= px;
			point_y_q <= py;
			last_q    <= k_q == LAST_POINT;
			done_q    <= (k_q == LAST_POINT) && job_q.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> last_q) else $error("circle_done without last_of_step");

	a_mid_step_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != '0 |-> job_valid_q) else $error("point index advanced with no job");

	a_eighth_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_end |=> out_valid_q && last_q) else $error("eighth point not marked last");

endmodule

[hw/rtl/circle_point_generator.sv]
// Top level of the midpoint circle point generator: configuration registers and the three stages.
// A step's first point passes the job queue, then the job register and the output register.
// Throughput: one point per cycle while out_stall is low, at the single output register;
// requests that emit nothing are taken at one per cycle while the queue is not full.
// A two-entry job queue lets the request side run ahead by up to two steps.
// Reset clears the configuration, the arc state (idle until a restart), the queue and out_valid.
module circle_point_generator import cpg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OUT_BITS-1:0]     point_x,
	output logic [OUT_BITS-1:0]     point_y,
	output logic                    last_of_step,
	output logic                    circle_done
);

	logic [COORD_BITS-1:0] centre_x_q;
	logic [COORD_BITS-1:0] centre_y_q;
	logic [RAD_BITS-1:0]   radius_q;

	logic     push;
	cpg_job_t push_job;
	logic     pop;
	logic     queue_full;
	logic     head_valid;
	cpg_job_t head_job;

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			radius_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CENTRE_X: centre_x_q <= cfg_data;
				REG_CENTRE_Y: centre_y_q <= cfg_data;
				REG_RADIUS:   radius_q   <= cfg_data[RAD_BITS-1:0];
				default: ;
			endcase
		end
	end

	cpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.restart    (restart),
		.queue_full (queue_full),
		.radius     (radius_q),
		.in_stall   (in_stall),
		.push       (push),
		.push_job   (push_job)
	);

	cpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	cpg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.centre_x     (centre_x_q),
		.centre_y     (centre_y_q),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule

[dv/tb_circle_point_generator.sv]
// Self-checking testbench for the midpoint circle point generator.
module tb_circle_point_generator;
	import cpg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES  = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int ITEMS_PER_SET = 50;
	localparam int SET_COUNT     = 8;

	// index with no register behind it
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_CENTRE} row_check_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [COORD_BITS-1:0]   data;
		logic                    rs;
		row_check_t              chk;
		int                      ex;
		int                      ey;
	} plan_row_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] px;
		logic [OUT_BITS-1:0] py;
		logic                last;
		logic                done;
	} pixel_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_CENTRE_X;
	logic [COORD_BITS-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    restart = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [OUT_BITS-1:0]     point_x;
	logic [OUT_BITS-1:0]     point_y;
	logic                    last_of_step;
	logic                    circle_done;

	// shadow registers and arc state of the predictor
	logic [COORD_BITS-1:0]      cx_reg = '0;
	logic [COORD_BITS-1:0]      cy_reg = '0;
	logic [RAD_BITS-1:0]        rad_reg = '0;
	logic [COORD_BITS-1:0]      arc_x_q = '0;
	logic [COORD_BITS-1:0]      arc_y_q = '0;
	logic signed [DEC_BITS-1:0] dec_q = '0;
	logic                       arc_live = 1'b0;

	pixel_t    step_pixels [$];
	pixel_t    pixel_q [$];
	plan_row_t plan [$];

	int err_count = 0;
	int quiet_cycles = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int gap_pct_by_mode [4] = '{0, 51, 0, 19};
	int stall_pct_by_mode [4] = '{0, 0, 51, 19};

	circle_point_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

	always #5 clk = ~clk;

	// reload on restart, mirror the arc position into eight pixels, then advance the arc
	function automatic void advance_arc(input logic rs);
		int cx, cy, x, y, d, nx, ny, a, b;
		pixel_t p;
		step_pixels.delete();
		if (rs) begin
			arc_x_q = '0;
			arc_y_q = COORD_BITS'(rad_reg);
			dec_q = DEC_BITS'(int'(DEC_INIT) - 2 * int'(rad_reg));
			arc_live = 1'b1;
		end
		if (!arc_live)
			return;
		cx = int'($signed(cx_reg));
		cy = int'($signed(cy_reg));
		x = int'(arc_x_q);
		y = int'(arc_y_q);
		d = int'(dec_q);
		ny = y;
		if (d < 0) begin
			d = d + 4 * x + int'(STEP_FLAT);
		end else begin
			d = d + 4 * (x - y) + int'(STEP_DIAG);
			ny = y - 1;
		end
		nx = x + 1;
		arc_live = (nx <= ny);
		arc_x_q = COORD_BITS'(nx);
		arc_y_q = COORD_BITS'(ny);
		dec_q = DEC_BITS'(d);
		// first four swing x about the centre, last four swap the roles of x and y
		for (int k = 0; k <= int'(LAST_POINT); k++) begin
			a = (k < 4) ? x : y;
			b = (k < 4) ? y : x;
			p.px = OUT_BITS'(((k & 1) != 0) ? cx - a : cx + a);
			p.py = OUT_BITS'(((k & 2) != 0) ? cy - b : cy + b);
			p.last = (k == int'(LAST_POINT));
			p.done = (k == int'(LAST_POINT)) && !arc_live;
			step_pixels.push_back(p);
		end
	endfunction

	// write one register and mirror it in the shadow copy
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COORD_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_CENTRE_X: cx_reg = data;
			REG_CENTRE_Y: cy_reg = data;
			REG_RADIUS: rad_reg = data[RAD_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold off until every pixel has come out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// offer one step request, log its pixels once taken, then maybe idle
	task automatic send_step(input logic rs, input row_check_t chk, input int ex, input int ey);
		pixel_t p;
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
		advance_arc(rs);
		case (chk)
			CHK_MODEL: begin
				foreach (step_pixels[i])
					pixel_q.push_back(step_pixels[i]);
			end
			CHK_CENTRE: begin
				for (int k = 0; k <= int'(LAST_POINT); k++) begin
					p.px = OUT_BITS'(ex);
					p.py = OUT_BITS'(ey);
					p.last = (k == int'(LAST_POINT));
					p.done = (k == int'(LAST_POINT));
					pixel_q.push_back(p);
				end
			end
			default: ;
		endcase
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			restart <= 1'($urandom_range(1));
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
	endtask

	// drive receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// compare each pixel transaction with the oldest expectation
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				$error("pixel with no step pending: x=%0d y=%0d",
					$signed(point_x), $signed(point_y));
				err_count++;
			end else begin
				want = pixel_q.pop_front();
				if (point_x !== want.px) begin
					$error("point_x: expected %0d, got %0d", $signed(want.px), $signed(point_x));
					err_count++;
				end
				if (point_y !== want.py) begin
					$error("point_y: expected %0d, got %0d", $signed(want.py), $signed(point_y));
					err_count++;
				end
				if (last_of_step !== want.last) begin
					$error("last_of_step: expected %0b, got %0b", want.last, last_of_step);
					err_count++;
				end
				if (circle_done !== want.done) begin
					$error("circle_done: expected %0b, got %0b", want.done, circle_done);
					err_count++;
				end
			end
		end
	end

	// end the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int counted;
		logic rs;
		int mode;
		plan = '{
			// idle request straight after reset
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_SILENT, 0, 0},
			'{ROW_WRITE, REG_CENTRE_X, 12'h800, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_WRITE, REG_CENTRE_Y, 12'h7FF, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_WRITE, REG_RADIUS,   12'h000, 1'b0, CHK_MODEL,  0, 0},
			// zero radius: centre pixel eight times, then idle
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b1, CHK_CENTRE, -2048, 2047},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_SILENT, 0, 0},
			// spare index must leave every register alone
			'{ROW_WRITE, REG_SPARE,    12'hFFF, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b1, CHK_CENTRE, -2048, 2047},
			// largest radius at the far corners of the centre range
			'{ROW_WRITE, REG_CENTRE_X, 12'h7FF, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_WRITE, REG_CENTRE_Y, 12'h800, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_WRITE, REG_RADIUS,   12'h7FF, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b1, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			// new radius mid-circle is not taken until a restart
			'{ROW_WRITE, REG_RADIUS,   12'h005, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			// new centre mid-circle applies at once
			'{ROW_WRITE, REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_WRITE, REG_CENTRE_Y, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			// a whole small circle, then an idle request
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b1, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b0, CHK_SILENT, 0, 0},
			// restart twice in a row, the second one mid-circle
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b1, CHK_MODEL,  0, 0},
			'{ROW_STEP,  REG_CENTRE_X, 12'h000, 1'b1, CHK_MODEL,  0, 0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table under moderate idling
		send_gap_pct = 19;
		stall_pct = 19;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_step(plan[i].rs, plan[i].chk, plan[i].ex, plan[i].ey);
			end
		end

		// random circles, one register setting per set, idling modes in turn
		for (int set = 0; set < SET_COUNT; set++) begin
			settle();
			mode = set % 4;
			send_gap_pct = gap_pct_by_mode[mode];
			stall_pct = stall_pct_by_mode[mode];
			case (set)
				2: begin
					write_reg(REG_CENTRE_X, 12'h800);
					write_reg(REG_CENTRE_Y, 12'h800);
					write_reg(REG_RADIUS, 12'hFFF);
				end
				5: begin
					write_reg(REG_CENTRE_X, 12'h7FF);
					write_reg(REG_CENTRE_Y, 12'h7FF);
					write_reg(REG_RADIUS, COORD_BITS'($urandom_range(4095)));
				end
				default: begin
					write_reg(REG_CENTRE_X, COORD_BITS'($urandom_range(4095)));
					write_reg(REG_CENTRE_Y, COORD_BITS'($urandom_range(4095)));
					write_reg(REG_RADIUS,
						{1'($urandom_range(1)), RAD_BITS'($urandom_range(40))});
				end
			endcase
			counted = 0;
			while (counted < ITEMS_PER_SET) begin
				// mostly whole arcs: restart when idle, seldom mid-circle
				rs = arc_live ? ($urandom_range(99) < 6) : ($urandom_range(99) < 85);
				send_step(rs, CHK_MODEL, 0, 0);
				if (step_pixels.size() != 0)
					counted++;
			end
		end

		settle();
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
